[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is held.
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[hdl/stdt_pkg.sv]
// Types and constants of the sigma threshold touch detector.
package stdt_pkg;

  localparam int SMP_W      = 13;   // raw sample width, signed
  localparam int FUNC_W     = 2;
  localparam int COOL_W     = 16;
  localparam int KS_W       = 16;
  localparam int WSZ_W      = 7;
  localparam int CFG_DATA_W = 16;
  localparam int MUL_W      = 32;   // shared multiplier operand width
  localparam int PROD_W     = 2 * MUL_W;
  localparam int LHS_SH     = 16;   // k_sigma has 8 fraction bits, squared
  localparam int FLOOR_SH   = 4;    // sigma floor 4, squared is 16
  localparam int WS_MIN     = 2;
  localparam int WS_DEF     = 64;
  localparam logic [KS_W-1:0] KS_RST = 16'd768;

  typedef enum logic [FUNC_W-1:0] {
    FN_SAMPLE   = 2'd0,
    FN_COOLDOWN = 2'd1,
    FN_CLEAR    = 2'd2,
    FN_NOP      = 2'd3
  } func_t;

  typedef enum logic [0:0] {
    CFG_WINDOW_SIZE = 1'b0,
    CFG_K_SIGMA     = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIN
  } state_t;

  // One code per multiplier issue slot; SP_LAST only drains the last product.
  typedef enum logic [3:0] {
    SP_NX, SP_NN, SP_SS, SP_NQLO, SP_NQHI, SP_KK,
    SP_DD, SP_KELO, SP_KEHI, SP_XX, SP_OO, SP_LAST
  } step_t;

endpackage

[hdl/stdt_in_if.sv]
// Input word channel: valid/ready with func, sample and cooldown count.
interface stdt_in_if import stdt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [SMP_W-1:0]  sample;
  logic [COOL_W-1:0]        cooldown_count;

  modport source (output valid, func, sample, cooldown_count, input ready);
  modport sink   (input valid, func, sample, cooldown_count, output ready);
endinterface

[hdl/stdt_out_if.sv]
// Result word channel: valid/ready with touch state and edge flags.
interface stdt_out_if;
  logic valid;
  logic ready;
  logic touching;
  logic rose;
  logic fell;

  modport source (output valid, touching, rose, fell, input ready);
  modport sink   (input valid, touching, rose, fell, output ready);
endinterface

[hdl/stdt_mul.sv]
// Shared unsigned multiplier with registered product.
module stdt_mul import stdt_pkg::*; (
  input  logic              clk,
  input  logic [MUL_W-1:0]  op_a,
  input  logic [MUL_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

[hdl/sigma_threshold_touch_detector.sv]
// Top level: adaptive mean plus k-sigma touch detector over an idle baseline window.
//
// Each input word carries a func code. A sample word (func 0) is tested against
// the mean and population sigma of up to window_size earlier idle samples: it
// counts as touching when the window is not empty and sample - mean exceeds
// (k_sigma/256) * max(sigma, 4). The test is exact, done on squared integers
// (D = n*x - S, V = n*Q - S*S, touch when D > 0 and 65536*D*D > k^2*max(V,16n^2)).
// Non-touching samples enter the ring, evicting the oldest once full. Rising and
// falling edges are reported unless a cooldown is running. Func 1 loads a new
// cooldown count, func 2 empties the window, func 3 does nothing; each word
// gives exactly one result word. A sample word passes from the accept state
// through the twelve sequencer steps to the finish state; other words go
// straight from accept to finish. The steps exist because one registered 32x32
// multiplier forms the eleven products of the test and the window update
// one after another. The block takes one word at a time; a finished result
// sits in the output register, so the next word is accepted while it waits.
// Config writes (window_size clamped to [2, MAX_WINDOW] and clearing the
// window; k_sigma) must be issued only while the block is idle.
module sigma_threshold_touch_detector import stdt_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  stdt_in_if.sink               in_chan,
  stdt_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LW       = $clog2(MAX_WINDOW);      // ring index bits
  localparam int CNT_W    = $clog2(MAX_WINDOW + 1);  // holds MAX_WINDOW itself
  localparam int SUM_W    = SMP_W + LW;              // signed window sum
  localparam int SQ1_W    = 2 * SMP_W - 1;           // one squared sample
  localparam int SQ_W     = SQ1_W + LW;              // window sum of squares
  localparam int D_W      = SUM_W + 1;               // n*x - S, signed
  localparam int E_W      = SQ_W + LW;               // variance term, unsigned
  localparam int V_W      = E_W + 1;                 // variance term, signed
  localparam int CMP_W    = MUL_W + E_W;             // both sides of the test
  localparam int WS_CMP_W = (CNT_W > WSZ_W) ? CNT_W : WSZ_W;
  localparam int WS_RST   = (MAX_WINDOW < WS_DEF) ? MAX_WINDOW : WS_DEF;

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic   in_ready, in_acc, calc_en, fin_go, slot_free;

  // Latched input word
  func_t                   func_r;
  logic signed [SMP_W-1:0] x_r;
  logic [COOL_W-1:0]       cool_in_r;

  // Baseline ring and its statistics
  logic signed [SMP_W-1:0] ring [MAX_WINDOW];
  logic signed [SMP_W-1:0] old_r;
  logic                    ring_we;
  logic [LW-1:0]           pos_r, pos_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic                    touch_r, touch_nxt;
  logic [COOL_W-1:0]       cool_r, cool_nxt;
  logic [CNT_W-1:0]        ws_r, ws_nxt;
  logic [KS_W-1:0]         ks_r, ks_nxt;

  // Datapath registers of the threshold test
  logic signed [D_W-1:0]   d_r;
  logic [E_W-1:0]          f_r, e_r;
  logic signed [V_W-1:0]   v_r;
  logic [MUL_W-1:0]        k2_r;
  logic [CMP_W-1:0]        lhs_r, rhs_r;
  logic [SQ1_W-1:0]        xsq_r, osq_r;
  logic                    now_r;

  // Output register
  logic out_valid_r, out_valid_nxt;
  logic touching_r, rose_r, fell_r;
  logic rose_nxt, fell_nxt;

  // Shared multiplier
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;

  stdt_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_p)
  );

  // ---------------------------------------------------------------------------
  // Magnitudes and operand slices
  // ---------------------------------------------------------------------------
  logic [SMP_W-1:0]        x_mag, o_mag;
  logic [SUM_W-1:0]        s_mag;
  logic [D_W-1:0]          d_mag, nx_mag;
  logic signed [D_W-1:0]   nx_s, d_calc;
  logic [PROD_W-1:0]       q64, e64;
  logic [E_W-1:0]          v_pos, e_calc;

  assign x_mag = x_r[SMP_W-1]   ? SMP_W'(-x_r)   : SMP_W'(x_r);
  assign o_mag = old_r[SMP_W-1] ? SMP_W'(-old_r) : SMP_W'(old_r);
  assign s_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign d_mag = d_r[D_W-1]     ? D_W'(-d_r)     : D_W'(d_r);
  assign q64   = PROD_W'(sq_r);
  assign e64   = PROD_W'(e_r);

  // n*x from the magnitude product, then D = n*x - S
  assign nx_mag = D_W'(mul_p);
  assign nx_s   = x_r[SMP_W-1] ? -$signed(nx_mag) : $signed(nx_mag);
  assign d_calc = nx_s - D_W'(sum_r);

  // Variance term clamped at zero, then floored at 16*n*n
  assign v_pos  = v_r[V_W-1] ? '0 : E_W'(v_r);
  assign e_calc = (v_pos < f_r) ? f_r : v_pos;

  always_comb begin
    case (step_r)
      SP_NX:   begin mul_a = MUL_W'(fill_r); mul_b = MUL_W'(x_mag);  end
      SP_NN:   begin mul_a = MUL_W'(fill_r); mul_b = MUL_W'(fill_r); end
      SP_SS:   begin mul_a = MUL_W'(s_mag);  mul_b = MUL_W'(s_mag);  end
      SP_NQLO: begin mul_a = MUL_W'(fill_r); mul_b = q64[MUL_W-1:0]; end
      SP_NQHI: begin mul_a = MUL_W'(fill_r); mul_b = q64[PROD_W-1:MUL_W]; end
      SP_KK:   begin mul_a = MUL_W'(ks_r);   mul_b = MUL_W'(ks_r);   end
      SP_DD:   begin mul_a = MUL_W'(d_mag);  mul_b = MUL_W'(d_mag);  end
      SP_KELO: begin mul_a = k2_r;           mul_b = e64[MUL_W-1:0]; end
      SP_KEHI: begin mul_a = k2_r;           mul_b = e64[PROD_W-1:MUL_W]; end
      SP_XX:   begin mul_a = MUL_W'(x_mag);  mul_b = MUL_W'(x_mag);  end
      SP_OO:   begin mul_a = MUL_W'(o_mag);  mul_b = MUL_W'(o_mag);  end
      default: begin mul_a = '0;             mul_b = '0;             end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state and control outputs
  // ---------------------------------------------------------------------------
  assign slot_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          step_nxt  = SP_NX;
          state_nxt = (func_t'(in_chan.func) == FN_SAMPLE) ? ST_CALC : ST_FIN;
        end
      end
      ST_CALC: begin
        if (step_r == SP_LAST) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_t'(step_r + 4'd1);
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    in_acc   = in_ready && in_chan.valid;
    calc_en  = (state_r == ST_CALC);
    fin_go   = (state_r == ST_FIN) && slot_free;
  end

  // ---------------------------------------------------------------------------
  // Window, flag and config updates
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]    pos_inc;
  logic                ring_full;
  logic [WS_CMP_W-1:0] ws_req;

  assign pos_inc   = CNT_W'(pos_r) + CNT_W'(1);
  assign ring_full = (fill_r >= ws_r);
  assign ws_req    = WS_CMP_W'(cfg_data[WSZ_W-1:0]);

  always_comb begin
    pos_nxt   = pos_r;
    fill_nxt  = fill_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    touch_nxt = touch_r;
    cool_nxt  = cool_r;
    ws_nxt    = ws_r;
    ks_nxt    = ks_r;
    rose_nxt  = 1'b0;
    fell_nxt  = 1'b0;
    ring_we   = 1'b0;

    if (fin_go) begin
      case (func_r)
        FN_SAMPLE: begin
          touch_nxt = now_r;
          rose_nxt  = !touch_r && now_r;
          fell_nxt  = touch_r && !now_r;
          if (cool_r != '0) begin
            rose_nxt = 1'b0;
            fell_nxt = 1'b0;
            cool_nxt = cool_r - COOL_W'(1);
          end
          if (!now_r) begin
            ring_we = 1'b1;
            if (ring_full) begin
              sum_nxt = sum_r - SUM_W'(old_r) + SUM_W'(x_r);
              sq_nxt  = sq_r - SQ_W'(osq_r) + SQ_W'(xsq_r);
            end else begin
              fill_nxt = fill_r + CNT_W'(1);
              sum_nxt  = sum_r + SUM_W'(x_r);
              sq_nxt   = sq_r + SQ_W'(xsq_r);
            end
            pos_nxt = (pos_inc >= ws_r) ? '0 : LW'(pos_inc);
          end
        end
        FN_COOLDOWN: cool_nxt = cool_in_r;
        FN_CLEAR: begin
          pos_nxt  = '0;
          fill_nxt = '0;
          sum_nxt  = '0;
          sq_nxt   = '0;
        end
        default: ;
      endcase
    end

    // The user must issue config only while idle, so it never meets a finish cycle; the block does not enforce this
    if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_SIZE: begin
          if (ws_req < WS_CMP_W'(WS_MIN)) begin
            ws_nxt = CNT_W'(WS_MIN);
          end else if (ws_req > WS_CMP_W'(MAX_WINDOW)) begin
            ws_nxt = CNT_W'(MAX_WINDOW);
          end else begin
            ws_nxt = CNT_W'(ws_req);
          end
          pos_nxt  = '0;
          fill_nxt = '0;
          sum_nxt  = '0;
          sq_nxt   = '0;
        end
        CFG_K_SIGMA: ks_nxt = cfg_data[KS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SP_NX;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      touch_r     <= 1'b0;
      cool_r      <= '0;
      ws_r        <= CNT_W'(WS_RST);
      ks_r        <= KS_RST;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      touch_r     <= touch_nxt;
      cool_r      <= cool_nxt;
      ws_r        <= ws_nxt;
      ks_r        <= ks_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r    <= func_t'(in_chan.func);
      x_r       <= in_chan.sample;
      cool_in_r <= in_chan.cooldown_count;
    end
    if (fin_go) begin
      touching_r <= touch_nxt;
      rose_r     <= rose_nxt;
      fell_r     <= fell_nxt;
    end
  end

  // Each step takes the product issued on the step before
  always_ff @(posedge clk) begin
    if (calc_en) begin
      case (step_r)
        SP_NN:   d_r <= d_calc;
        SP_SS:   f_r <= E_W'(mul_p) << FLOOR_SH;
        SP_NQLO: v_r <= -$signed(V_W'(mul_p));
        SP_NQHI: v_r <= v_r + $signed(V_W'(mul_p));
        SP_KK:   v_r <= v_r + $signed(V_W'(mul_p) << MUL_W);
        SP_DD: begin
          k2_r <= mul_p[MUL_W-1:0];
          e_r  <= e_calc;
        end
        SP_KELO: lhs_r <= CMP_W'(mul_p) << LHS_SH;
        SP_KEHI: rhs_r <= CMP_W'(mul_p);
        SP_XX:   rhs_r <= rhs_r + (CMP_W'(mul_p) << MUL_W);
        SP_OO: begin
          xsq_r <= mul_p[SQ1_W-1:0];
          now_r <= (fill_r != '0) && !d_r[D_W-1] && (d_r != '0) && (lhs_r > rhs_r);
        end
        SP_LAST: osq_r <= mul_p[SQ1_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring memory: one write port, registered read of the slot about to be replaced
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[pos_r] <= x_r;
    end
    old_r <= ring[pos_r];
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign in_chan.ready     = in_ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.touching = touching_r;
  assign out_chan.rose     = rose_r;
  assign out_chan.fell     = fell_r;

endmodule

[hdl/stdt_chk.sv]
// Port checker for the touch detector, bound to the top level.
`include "assert_macros.svh"

module stdt_chk (
  input logic        clk,
  input logic        rst_n,
  stdt_in_if.sink    in_chan,
  stdt_out_if.source out_chan
);

  // A stalled result word stays offered
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_chan.valid && !out_chan.ready, out_chan.valid)

  // One word in flight: no acceptance right after an acceptance
  `ASSERT_NXT(a_one_word, clk, rst_n, in_chan.valid && in_chan.ready, !in_chan.ready)

  // A rising edge leaves the detector touching
  `ASSERT_IMP(a_rose_touch, clk, rst_n, out_chan.valid && out_chan.rose, out_chan.touching)

  // A falling edge leaves the detector released
  `ASSERT_IMP(a_fell_idle, clk, rst_n, out_chan.valid && out_chan.fell, !out_chan.touching)

endmodule

bind sigma_threshold_touch_detector stdt_chk u_stdt_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);
